### src/stable_priority_queue_assert.svh
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Overlapping implication checked at every clock edge out of reset.
`define SPQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int VALUE_BITS    = 32;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int OCC_W         = 5;
  localparam int STATUS_W      = 2;

  localparam logic [0:0] FUNC_ENQ = 1'b0;
  localparam logic [0:0] FUNC_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_PUT,
    S_DEQ_HEAD,
    S_DEQ_RD,
    S_DEQ_MV,
    S_RESP
  } state_t;

endpackage

### src/stable_priority_queue.sv
// Sorted priority queue of up to 16 (priority, value) entries, highest priority
// first, equal priorities leaving in arrival order. One word is taken at a time:
// in_ready is high only while the sequencer is idle. Entries live in a
// single-port-write, registered-read memory, and one shared compare-and-move
// step walks it one entry at a time. An enqueue compares from the tail, moving
// each entry of lower priority one slot toward the tail, and writes the new
// entry into the freed slot (an empty queue takes it directly, a full one
// refuses it); a dequeue takes the head and moves the remaining entries one slot
// toward the head. The result sits in an output register, so the next word
// may be accepted while it waits.
module stable_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [7:0]                        priority_req,
  input  logic signed [spq_pkg::VALUE_BITS-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::STATUS_W-1:0]      status,
  output logic [7:0]                        out_priority,
  output logic signed [spq_pkg::VALUE_BITS-1:0] out_value,
  output logic [spq_pkg::OCC_W-1:0]         occupancy
);
  import spq_pkg::*;

  logic [PRIORITY_BITS-1:0] prio_mem [CAPACITY];
  logic [VALUE_BITS-1:0]    val_mem  [CAPACITY];

  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         count;
  logic [ADDR_W-1:0]        idx;
  logic [PRIORITY_BITS-1:0] req_pri;
  logic [VALUE_BITS-1:0]    req_val;
  logic [STATUS_W-1:0]      res_status;
  logic [PRIORITY_BITS-1:0] res_pri;
  logic [VALUE_BITS-1:0]    res_val;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [VALUE_BITS-1:0]    rd_val;

  logic                     in_fire;
  logic                     out_free;
  logic                     is_full;
  logic                     is_empty;
  logic                     shift_down;
  logic                     last_move;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [PRIORITY_BITS-1:0] wr_pri;
  logic [VALUE_BITS-1:0]    wr_val;

  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign is_full    = (count == CNT_W'(CAPACITY));
  assign is_empty   = (count == '0);
  assign shift_down = (rd_pri < req_pri);
  assign last_move  = (CNT_W'(idx) == count - CNT_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (func == FUNC_ENQ) begin
            state_next = (is_full || is_empty) ? S_RESP : S_ENQ_RD;
          end else begin
            state_next = is_empty ? S_RESP : S_DEQ_HEAD;
          end
        end
      end
      S_ENQ_RD:  state_next = S_ENQ_CMP;
      S_ENQ_CMP: begin
        if (!shift_down) state_next = S_RESP;
        else if (idx == '0) state_next = S_ENQ_PUT;
        else state_next = S_ENQ_RD;
      end
      S_ENQ_PUT:  state_next = S_RESP;
      S_DEQ_HEAD: state_next = (count == CNT_W'(1)) ? S_RESP : S_DEQ_RD;
      S_DEQ_RD:   state_next = S_DEQ_MV;
      S_DEQ_MV:   state_next = last_move ? S_RESP : S_DEQ_RD;
      S_RESP:     state_next = out_free ? S_IDLE : S_RESP;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_pri   = req_pri;
    wr_val   = req_val;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // first entry goes straight in
        if (in_fire && func == FUNC_ENQ && is_empty) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_pri  = priority_req[PRIORITY_BITS-1:0];
          wr_val  = value;
        end
      end
      S_ENQ_RD: rd_addr = idx;
      S_ENQ_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx + ADDR_W'(1);
        if (shift_down) begin
          wr_pri = rd_pri;
          wr_val = rd_val;
        end
      end
      S_ENQ_PUT: wr_en = 1'b1;
      S_DEQ_RD:  rd_addr = idx;
      S_DEQ_MV: begin
        wr_en   = 1'b1;
        wr_addr = idx - ADDR_W'(1);
        wr_pri  = rd_pri;
        wr_val  = rd_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_pri;
      val_mem[wr_addr]  <= wr_val;
    end
    rd_pri <= prio_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESP && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire && func == FUNC_ENQ && is_empty) count <= count + CNT_W'(1);
        end
        S_ENQ_CMP: begin
          if (!shift_down) count <= count + CNT_W'(1);
        end
        S_ENQ_PUT: count <= count + CNT_W'(1);
        S_DEQ_HEAD: begin
          if (count == CNT_W'(1)) count <= '0;
        end
        S_DEQ_MV: begin
          if (last_move) count <= count - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          req_pri <= priority_req[PRIORITY_BITS-1:0];
          req_val <= value;
          idx     <= ADDR_W'(count - CNT_W'(1));
          res_pri <= '0;
          res_val <= '0;
          if (func == FUNC_ENQ) res_status <= is_full ? ST_FULL : ST_OK;
          else res_status <= is_empty ? ST_EMPTY : ST_OK;
        end
      end
      S_ENQ_CMP: begin
        if (shift_down && idx != '0) idx <= idx - ADDR_W'(1);
      end
      S_DEQ_HEAD: begin
        res_pri <= rd_pri;
        res_val <= rd_val;
        idx     <= ADDR_W'(1);
      end
      S_DEQ_MV: begin
        if (!last_move) idx <= idx + ADDR_W'(1);
      end
      S_RESP: begin
        if (out_free) begin
          status       <= res_status;
          out_priority <= 8'(res_pri);
          out_value    <= res_val;
          occupancy    <= OCC_W'(count);
        end
      end
      default: ;
    endcase
  end

`include "stable_priority_queue_assert.svh"

  `SPQ_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `SPQ_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "new word taken while busy")
  `SPQ_ASSERT_IMPLY(a_full_occ, out_valid && status == ST_FULL, occupancy == OCC_W'(CAPACITY), "full reported below capacity")
  `SPQ_ASSERT_IMPLY(a_empty_occ, out_valid && status == ST_EMPTY, occupancy == '0, "empty reported with entries held")
  `SPQ_ASSERT_NEXT(a_count_step, 1'b1, count == $past(count) || count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1), "entry count jumped")

endmodule

### test/tb.sv
module tb;
  import spq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [7:0]          pri;
    logic [31:0]         val;
    logic [OCC_W-1:0]    occ;
  } res_t;

  // one directed word; chk set where the expected result is typed in
  typedef struct packed {
    logic [0:0]          f;
    logic [7:0]          pri;
    logic [31:0]         val;
    logic                chk;
    logic [STATUS_W-1:0] st;
    logic [7:0]          opri;
    logic [31:0]         oval;
    logic [OCC_W-1:0]    occ;
  } dir_row_t;

  localparam int DIR_N  = 25;
  localparam int RAND_N = 1425;
  localparam int CALM_N = 200;

  dir_row_t dir_tab [DIR_N] = '{
    '{FUNC_DEQ, 8'd0,   32'h0000_0000, 1'b1, ST_EMPTY, 8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'd0,   32'h8000_0000, 1'b1, ST_OK,    8'd0,   32'h0000_0000, 5'd1},
    '{FUNC_ENQ, 8'd255, 32'h7fff_ffff, 1'b1, ST_OK,    8'd0,   32'h0000_0000, 5'd2},
    '{FUNC_ENQ, 8'd255, 32'h0000_0001, 1'b1, ST_OK,    8'd0,   32'h0000_0000, 5'd3},
    '{FUNC_DEQ, 8'd0,   32'h0000_0000, 1'b1, ST_OK,    8'd255, 32'h7fff_ffff, 5'd2},
    '{FUNC_DEQ, 8'd0,   32'h0000_0000, 1'b1, ST_OK,    8'd255, 32'h0000_0001, 5'd1},
    '{FUNC_DEQ, 8'd0,   32'h0000_0000, 1'b1, ST_OK,    8'd0,   32'h8000_0000, 5'd0},
    '{FUNC_DEQ, 8'd255, 32'hffff_ffff, 1'b1, ST_EMPTY, 8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h55,  32'h5555_5555, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'haa,  32'haaaa_aaaa, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'hff,  32'hffff_ffff, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h00,  32'h0000_0000, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h55,  32'h1234_5678, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h80,  32'h8000_0001, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h01,  32'hdead_beef, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'haa,  32'h5555_aaaa, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h7f,  32'h7fff_0000, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h00,  32'h0000_ffff, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'hff,  32'h0f0f_0f0f, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h55,  32'hf0f0_f0f0, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h10,  32'h0000_0010, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h80,  32'hc000_0003, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'hfe,  32'h3333_cccc, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'h02,  32'h0000_0002, 1'b0, ST_OK,    8'd0,   32'h0000_0000, 5'd0},
    '{FUNC_ENQ, 8'hff,  32'h7777_7777, 1'b1, ST_FULL,  8'd0,   32'h0000_0000, 5'd16}
  };

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic                         func         = FUNC_ENQ;
  logic [7:0]                   priority_req = 8'd0;
  logic signed [VALUE_BITS-1:0] value        = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic [STATUS_W-1:0]          status;
  logic [7:0]                   out_priority;
  logic signed [VALUE_BITS-1:0] out_value;
  logic [OCC_W-1:0]             occupancy;

  // own copy of the sorted entry store
  logic [7:0]  ent_pri [CAPACITY];
  logic [31:0] ent_val [CAPACITY];
  int          ent_cnt = 0;

  res_t pending_res [$];
  int   n_bad     = 0;
  bit   idle_on   = 1'b1;
  int   stall_left = 0;

  stable_priority_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .priority_req (priority_req),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_priority (out_priority),
    .out_value    (out_value),
    .occupancy    (occupancy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // work out the result of one accepted word and update the entry store
  task automatic queue_step(input logic [0:0] f, input logic [7:0] p, input logic [31:0] v,
                            output res_t r);
    int pos;
    int i;
    pos = 0;
    r = '{st: ST_OK, pri: 8'd0, val: 32'd0, occ: '0};
    if (f == FUNC_ENQ) begin
      if (ent_cnt >= CAPACITY) begin
        r.st = ST_FULL;
      end else begin
        // equal priorities stay behind the older entries
        while (pos < ent_cnt && ent_pri[pos] >= p) pos++;
        for (i = ent_cnt; i > pos; i--) begin
          ent_pri[i] = ent_pri[i-1];
          ent_val[i] = ent_val[i-1];
        end
        ent_pri[pos] = p;
        ent_val[pos] = v;
        ent_cnt++;
      end
    end else begin
      if (ent_cnt == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.pri = ent_pri[0];
        r.val = ent_val[0];
        for (i = 1; i < ent_cnt; i++) begin
          ent_pri[i-1] = ent_pri[i];
          ent_val[i-1] = ent_val[i];
        end
        ent_cnt--;
      end
    end
    r.occ = ent_cnt[OCC_W-1:0];
  endtask

  // present one word, hold it until taken, then predict its result
  task automatic send_word(input logic [0:0] f, input logic [7:0] p, input logic [31:0] v,
                           output res_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    priority_req <= p;
    value        <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_step(f, p, v, r);
  endtask

  // receiver: random stall bursts, none once idling is switched off
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d pri %0d value %h occ %0d",
                 $time, status, out_priority, out_value, occupancy);
        n_bad++;
      end else begin
        e = pending_res.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          n_bad++;
        end
        if (out_priority !== e.pri) begin
          $display("%0t: out_priority expected %0d actual %0d", $time, e.pri, out_priority);
          n_bad++;
        end
        if (out_value !== e.val) begin
          $display("%0t: out_value expected %h actual %h", $time, e.val, out_value);
          n_bad++;
        end
        if (occupancy !== e.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occupancy);
          n_bad++;
        end
      end
    end
  end

  initial begin
    int          r;
    int          k;
    int          mode;
    int          enq_pct;
    res_t        exp_r;
    logic [0:0]  f;
    logic [7:0]  p;
    logic [31:0] v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_N; r++) begin
      send_word(dir_tab[r].f, dir_tab[r].pri, dir_tab[r].val, exp_r);
      if (dir_tab[r].chk)
        pending_res.push_back('{st: dir_tab[r].st, pri: dir_tab[r].opri,
                                val: dir_tab[r].oval, occ: dir_tab[r].occ});
      else
        pending_res.push_back(exp_r);
    end

    // hold the sender until the queue has answered everything
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);

    mode = 0;
    for (k = 0; k < RAND_N; k++) begin
      if (k % 40 == 0) mode = $urandom_range(0, 3);
      if (k == RAND_N / 2) begin
        in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
      end
      if (k == RAND_N - CALM_N) idle_on <= 1'b0;
      // fill-heavy and drain-heavy stretches push the queue to full and empty
      enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      if (mode == 3)
        p = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                 : ($urandom_range(0, 1) ? 8'hff : 8'h00);
      else if ($urandom_range(0, 4) == 0)
        p = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else
        p = 8'($urandom);
      if ($urandom_range(0, 9) == 0)
        v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      else
        v = $urandom;
      send_word(f, p, v, exp_r);
      pending_res.push_back(exp_r);
    end

    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_bad == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
